FILE: rtl/core/pscm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscm_pkg
// Shared types and constants of the polyline segment clip and map core.
// ----------------------------------------------------------------------------
package pscm_pkg;

  localparam int CoordW    = 32;
  localparam int PixW      = 16;
  localparam int PixOffW   = 12;
  localparam int CfgIdxW   = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_WIN_X_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIN_X_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIN_Y_MIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WIN_Y_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SCALE_Y    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PIX_LEFT   = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_PIX_BOTTOM = 3'd7;

  // one segment; a is the coordinate under test in a pass, b the other one
  typedef struct packed {
    logic signed [CoordW-1:0] a1;
    logic signed [CoordW-1:0] b1;
    logic signed [CoordW-1:0] a2;
    logic signed [CoordW-1:0] b2;
  } pscm_seg_t;

  // pipeline control shared between stage groups
  typedef struct packed {
    logic en;
    logic valid;
  } pscm_ctl_t;

endpackage

FILE: rtl/core/polyline_segment_clip_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_segment_clip_map_core
// Clips polyline segments to a world window and maps them to pixels.
// ----------------------------------------------------------------------------
// Takes one vertex per cycle while the pipeline is not stalled, forms a
// segment with the previous vertex, drops segments wholly beyond one window
// edge, clips the rest against y_min, y_max, x_min and x_max and emits pixel
// end points. Throughput is one vertex per clock while not stalled; the depth
// is set mostly by the four 32-stage pipelined dividers of the clipping passes.
// A stalled output freezes the whole pipeline only while its last stage
// holds a segment. Write configuration only while the core is empty.
// ----------------------------------------------------------------------------
module polyline_segment_clip_map_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wen,
  input  logic [pscm_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_wdata,
  // vertex stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // point_x, point_y
  input  logic                          in_tuser,   // first_vertex
  // segment stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata   // start_col, start_row, end_col, end_row
);
  import pscm_pkg::*;

  localparam int MapLat = 3;

  // ---- configuration ----
  logic signed [31:0] win_x_min_r, win_x_max_r, win_y_min_r, win_y_max_r;
  logic [31:0]        scale_x_r, scale_y_r;
  logic [11:0]        pix_left_r, pix_bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_x_min_r  <= 32'sd0;
      win_x_max_r  <= 32'sd65536;
      win_y_min_r  <= 32'sd0;
      win_y_max_r  <= 32'sd65536;
      scale_x_r    <= 32'd65536;
      scale_y_r    <= 32'd65536;
      pix_left_r   <= 12'd0;
      pix_bottom_r <= 12'd479;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_WIN_X_MIN:  win_x_min_r  <= cfg_wdata;
        CFG_WIN_X_MAX:  win_x_max_r  <= cfg_wdata;
        CFG_WIN_Y_MIN:  win_y_min_r  <= cfg_wdata;
        CFG_WIN_Y_MAX:  win_y_max_r  <= cfg_wdata;
        CFG_SCALE_X:    scale_x_r    <= cfg_wdata;
        CFG_SCALE_Y:    scale_y_r    <= cfg_wdata;
        CFG_PIX_LEFT:   pix_left_r   <= cfg_wdata[11:0];
        CFG_PIX_BOTTOM: pix_bottom_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // ---- flow control ----
  logic out_load, adv, v_last;
  logic out_tvalid_r;
  assign out_load  = out_tready || !out_tvalid_r;
  assign adv       = out_load || !v_last;
  assign in_tready = adv;

  logic accept;
  assign accept = in_tvalid && in_tready;

  // ---- front stage: previous vertex and rejection ----
  logic signed [31:0] px_w, py_w;
  logic signed [31:0] prev_x_r, prev_y_r;
  logic               have_prev_r;
  logic               reject_w, use_w;

  assign px_w = in_tdata[31:0];
  assign py_w = in_tdata[63:32];

  always_comb begin
    use_w    = have_prev_r && !in_tuser;
    reject_w = (prev_y_r <= win_y_min_r && py_w <= win_y_min_r) ||
               (prev_y_r >= win_y_max_r && py_w >= win_y_max_r) ||
               (prev_x_r <= win_x_min_r && px_w <= win_x_min_r) ||
               (prev_x_r >= win_x_max_r && px_w >= win_x_max_r);
  end

  logic      v0_r;
  pscm_seg_t seg0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r    <= 32'sd0;
      prev_y_r    <= 32'sd0;
      v0_r        <= 1'b0;
    end else begin
      if (accept) begin
        have_prev_r <= 1'b1;
        prev_x_r    <= px_w;
        prev_y_r    <= py_w;
      end
      if (adv) begin
        v0_r <= accept && use_w && !reject_w;
      end
    end
    if (adv) begin
      // y passes test y, so y sits in the a slots
      seg0_r.a1 <= prev_y_r;
      seg0_r.b1 <= prev_x_r;
      seg0_r.a2 <= py_w;
      seg0_r.b2 <= px_w;
    end
  end

  // ---- clipping passes ----
  pscm_ctl_t ctl0, ctl1, ctl2, ctl3;
  logic      v1_w, v2_w, v3_w, v4_w;
  pscm_seg_t seg1_w, seg2_w, seg3_w, seg4_w, seg2x_w;

  assign ctl0 = '{en: adv, valid: v0_r};
  assign ctl1 = '{en: adv, valid: v1_w};
  assign ctl2 = '{en: adv, valid: v2_w};
  assign ctl3 = '{en: adv, valid: v3_w};

  pscm_pass u_pass_ymin (
    .clk, .rst_n, .ctl_in(ctl0), .seg_in(seg0_r), .level(win_y_min_r),
    .upper(1'b0), .valid_out(v1_w), .seg_out(seg1_w)
  );
  pscm_pass u_pass_ymax (
    .clk, .rst_n, .ctl_in(ctl1), .seg_in(seg1_w), .level(win_y_max_r),
    .upper(1'b1), .valid_out(v2_w), .seg_out(seg2_w)
  );

  // swap roles: x becomes the tested coordinate
  assign seg2x_w = '{a1: seg2_w.b1, b1: seg2_w.a1, a2: seg2_w.b2, b2: seg2_w.a2};

  pscm_pass u_pass_xmin (
    .clk, .rst_n, .ctl_in(ctl2), .seg_in(seg2x_w), .level(win_x_min_r),
    .upper(1'b0), .valid_out(v3_w), .seg_out(seg3_w)
  );
  pscm_pass u_pass_xmax (
    .clk, .rst_n, .ctl_in(ctl3), .seg_in(seg3_w), .level(win_x_max_r),
    .upper(1'b1), .valid_out(v4_w), .seg_out(seg4_w)
  );

  // ---- pixel mapping ----
  logic signed [15:0] scol_w, srow_w, ecol_w, erow_w;

  pscm_map u_map_scol (
    .clk, .en(adv), .coord(seg4_w.a1), .edge_lvl(win_x_min_r), .scale(scale_x_r),
    .pix_off(pix_left_r), .is_row(1'b0), .pix(scol_w)
  );
  pscm_map u_map_srow (
    .clk, .en(adv), .coord(seg4_w.b1), .edge_lvl(win_y_min_r), .scale(scale_y_r),
    .pix_off(pix_bottom_r), .is_row(1'b1), .pix(srow_w)
  );
  pscm_map u_map_ecol (
    .clk, .en(adv), .coord(seg4_w.a2), .edge_lvl(win_x_min_r), .scale(scale_x_r),
    .pix_off(pix_left_r), .is_row(1'b0), .pix(ecol_w)
  );
  pscm_map u_map_erow (
    .clk, .en(adv), .coord(seg4_w.b2), .edge_lvl(win_y_min_r), .scale(scale_y_r),
    .pix_off(pix_bottom_r), .is_row(1'b1), .pix(erow_w)
  );

  logic [MapLat-1:0] vmap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmap_r <= '0;
    end else if (adv) begin
      vmap_r <= {vmap_r[MapLat-2:0], v4_w};
    end
  end

  assign v_last = vmap_r[MapLat-1];

  // ---- output register ----
  logic [63:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= v_last;
    end
    if (out_load && v_last) begin
      out_tdata_r <= {erow_w, ecol_w, srow_w, scol_w};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // every accepted vertex leaves a valid previous vertex behind
  a_prev_set: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> have_prev_r)
    else $error("previous vertex not recorded");

  // a frozen pipeline keeps its front stage
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v0_r))
    else $error("front stage moved during stall");

  // a stalled result with a full last stage freezes the pipeline
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready && v_last) |-> !in_tready)
    else $error("pipeline advanced over a held result");
`endif

endmodule

FILE: rtl/core/pscm_pass.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscm_pass
// One clipping pass: orders the ends by a, then cuts at the level with a
// pipelined restoring divider (setup, product, 32 quotient stages, update).
// ----------------------------------------------------------------------------
module pscm_pass (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pscm_pkg::pscm_ctl_t         ctl_in,
  input  pscm_pkg::pscm_seg_t         seg_in,
  input  logic signed [31:0]          level,
  input  logic                        upper,
  output logic                        valid_out,
  output pscm_pkg::pscm_seg_t         seg_out
);
  import pscm_pkg::*;

  localparam int QW = CoordW;

  // ---- setup stage ----
  pscm_seg_t         sw_seg;
  logic signed [32:0] d1_w, d2_w, da_w, db_w;
  logic [31:0]        mag_w;

  always_comb begin
    sw_seg = seg_in;
    if (seg_in.a1 > seg_in.a2) begin
      sw_seg.a1 = seg_in.a2;
      sw_seg.b1 = seg_in.b2;
      sw_seg.a2 = seg_in.a1;
      sw_seg.b2 = seg_in.b1;
    end
    d1_w  = {level[31], level} - {sw_seg.a1[31], sw_seg.a1};
    d2_w  = {sw_seg.a2[31], sw_seg.a2} - {level[31], level};
    da_w  = {sw_seg.a2[31], sw_seg.a2} - {sw_seg.a1[31], sw_seg.a1};
    db_w  = {sw_seg.b2[31], sw_seg.b2} - {sw_seg.b1[31], sw_seg.b1};
    mag_w = db_w[32] ? 32'(-db_w) : db_w[31:0];
  end

  logic        v1_r, cut1_r, near1_r, neg1_r;
  pscm_seg_t   seg1_r;
  logic [31:0] mag1_r, d1sel_r, da1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ctl_in.en) begin
      v1_r <= ctl_in.valid;
    end
    if (ctl_in.en) begin
      seg1_r  <= sw_seg;
      cut1_r  <= (sw_seg.a2 > level) && (sw_seg.a1 < level);
      near1_r <= d2_w > d1_w;
      neg1_r  <= db_w[32];
      mag1_r  <= mag_w;
      d1sel_r <= (d2_w > d1_w) ? d1_w[31:0] : d2_w[31:0];
      da1_r   <= da_w[31:0];
    end
  end

  // ---- divider stages; index 0 holds the product ----
  logic              v_r    [0:QW];
  logic              cut_r  [0:QW];
  logic              near_r [0:QW];
  logic              neg_r  [0:QW];
  pscm_seg_t         seg_r  [0:QW];
  logic [31:0]       da_r   [0:QW];
  logic [31:0]       rem_r  [0:QW];
  logic [31:0]       nlo_r  [0:QW];
  logic [31:0]       q_r    [0:QW];

  logic [63:0] prod_w;
  assign prod_w = mag1_r * d1sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ctl_in.en) begin
      v_r[0] <= v1_r;
    end
    if (ctl_in.en) begin
      cut_r[0]  <= cut1_r;
      near_r[0] <= near1_r;
      neg_r[0]  <= neg1_r;
      seg_r[0]  <= seg1_r;
      da_r[0]   <= da1_r;
      rem_r[0]  <= prod_w[63:32];
      nlo_r[0]  <= prod_w[31:0];
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [32:0] r2_w;
    logic        ge_w;
    assign r2_w = {rem_r[k-1], nlo_r[k-1][31]};
    assign ge_w = r2_w >= {1'b0, da_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl_in.en) begin
        v_r[k] <= v_r[k-1];
      end
      if (ctl_in.en) begin
        cut_r[k]  <= cut_r[k-1];
        near_r[k] <= near_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        seg_r[k]  <= seg_r[k-1];
        da_r[k]   <= da_r[k-1];
        rem_r[k]  <= ge_w ? 32'(r2_w - {1'b0, da_r[k-1]}) : r2_w[31:0];
        nlo_r[k]  <= {nlo_r[k-1][30:0], 1'b0};
        q_r[k]    <= {q_r[k-1][30:0], ge_w};
      end
    end
  end

  // ---- update stage ----
  logic signed [32:0] qs_w, b_w;
  pscm_seg_t          upd_seg;

  always_comb begin
    qs_w = neg_r[QW] ? -$signed({1'b0, q_r[QW]}) : $signed({1'b0, q_r[QW]});
    if (near_r[QW]) begin
      b_w = {seg_r[QW].b1[31], seg_r[QW].b1} + qs_w;
    end else begin
      b_w = {seg_r[QW].b2[31], seg_r[QW].b2} - qs_w;
    end
    upd_seg = seg_r[QW];
    if (cut_r[QW]) begin
      if (upper) begin
        upd_seg.a2 = level;
        upd_seg.b2 = b_w[31:0];
      end else begin
        upd_seg.a1 = level;
        upd_seg.b1 = b_w[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (ctl_in.en) begin
      valid_out <= v_r[QW];
    end
    if (ctl_in.en) begin
      seg_out <= upd_seg;
    end
  end

endmodule

FILE: rtl/core/pscm_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscm_map
// Maps one world coordinate to a saturated pixel coordinate in three stages:
// offset and magnitude, 32x32 product, scale-down with offset and saturation.
// ----------------------------------------------------------------------------
module pscm_map (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          coord,
  input  logic signed [31:0]          edge_lvl,
  input  logic [31:0]                 scale,
  input  logic [11:0]                 pix_off,
  input  logic                        is_row,
  output logic signed [15:0]          pix
);
  import pscm_pkg::*;

  logic signed [32:0] diff_w;
  assign diff_w = {coord[31], coord} - {edge_lvl[31], edge_lvl};

  // |coord - edge| never exceeds 2^32 - 1, so the magnitude fits 32 bits
  logic        neg0_r;
  logic [31:0] mag0_r;
  logic        neg1_r;
  logic [63:0] prod1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r  <= diff_w[32];
      mag0_r  <= diff_w[32] ? 32'(-diff_w) : diff_w[31:0];
      neg1_r  <= neg0_r;
      prod1_r <= mag0_r * scale;
    end
  end

  // a row or a negative offset, but not both, turns the add into a subtract
  logic               sub_w;
  logic signed [35:0] val_w;
  logic signed [15:0] sat_w;

  always_comb begin
    sub_w = is_row ^ neg1_r;
    if (sub_w) begin
      val_w = $signed({24'd0, pix_off}) - $signed({4'd0, prod1_r[63:32]});
    end else begin
      val_w = $signed({24'd0, pix_off}) + $signed({4'd0, prod1_r[63:32]});
    end
    if (val_w > 36'sd32767) begin
      sat_w = 16'sh7FFF;
    end else if (val_w < -36'sd32768) begin
      sat_w = -16'sh8000;
    end else begin
      sat_w = val_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix <= sat_w;
    end
  end

endmodule
